// ----- hdl/risc_subset_core_step_defines.svh -----
// assertion macros for the risc subset core step block
// no dependencies; included by files that carry concurrent assertions
`ifndef RISC_SUBSET_CORE_STEP_DEFINES_SVH
`define RISC_SUBSET_CORE_STEP_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define RSCS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define RSCS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define RSCS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define RSCS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ----- hdl/rscs_pkg.sv -----
// shared constants, types and helpers of the risc subset core step block
// no dependencies; used by the register file, data memory, execute and top-level files
`default_nettype none

package rscs_pkg;

   // data memory depth in words, power of two (word index = address bits above byte offset)
   localparam int unsigned DATA_WORDS = 1024;
   localparam int unsigned DMEM_AW    = $clog2(DATA_WORDS);

   localparam logic [31:0] RESET_PC    = 32'h0040_0000;
   localparam logic [31:0] GP_RESET    = 32'h1000_8000;
   localparam logic [31:0] SP_RESET    = 32'h1000_0000;
   localparam logic [4:0]  GP_REG      = 5'd28;
   localparam logic [4:0]  SP_REG      = 5'd29;
   localparam logic [4:0]  ZERO_REG    = 5'd0;
   localparam logic [31:0] REGION_MASK = 32'hf000_0000;

   // opcodes
   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_ADDIU   = 6'h09;
   localparam logic [5:0] OP_ANDI    = 6'h0c;
   localparam logic [5:0] OP_LW      = 6'h23;
   localparam logic [5:0] OP_SW      = 6'h2b;

   // function codes under OP_SPECIAL
   localparam logic [5:0] FN_SLL  = 6'h00;
   localparam logic [5:0] FN_SRA  = 6'h03;
   localparam logic [5:0] FN_MULT = 6'h18;
   localparam logic [5:0] FN_ADDU = 6'h21;
   localparam logic [5:0] FN_SUBU = 6'h23;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        reg_write;
      logic [4:0]  dest_reg;
      logic [31:0] write_value;
      logic        mem_store;
      logic [31:0] mem_address;
      logic [31:0] store_value;
      logic [31:0] hi_value;
      logic [31:0] lo_value;
      logic        unimplemented;
   } rsp_word_type;

   // state updates asked for by the execute logic
   typedef struct packed {
      logic               is_load;
      logic               reg_we;
      logic [4:0]         reg_addr;
      logic [31:0]        reg_data;
      logic               mem_we;
      logic [DMEM_AW-1:0] mem_index;
      logic [31:0]        mem_data;
      logic               hilo_we;
      logic [31:0]        hi;
      logic [31:0]        lo;
      logic [31:0]        npc;
   } exec_ctrl_type;

   // register file contents after reset
   function automatic logic [31:0] reg_reset_value(input logic [4:0] idx);
      logic [31:0] v;
      v = 32'd0;
      if (idx == GP_REG) begin
         v = GP_RESET;
      end else if (idx == SP_REG) begin
         v = SP_RESET;
      end
      return v;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/rscs_if.sv -----
// valid/ready channel interfaces of the risc subset core step block
// no dependencies
`default_nettype none

interface rscs_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] instruction;

   modport source (output valid, output instruction, input ready);
   modport sink   (input valid, input instruction, output ready);
endinterface

interface rscs_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] next_pc;
   logic        reg_write;
   logic [4:0]  dest_reg;
   logic [31:0] write_value;
   logic        mem_store;
   logic [31:0] mem_address;
   logic [31:0] store_value;
   logic [31:0] hi_value;
   logic [31:0] lo_value;
   logic        unimplemented;

   modport source (output valid, output next_pc, output reg_write, output dest_reg,
                   output write_value, output mem_store, output mem_address,
                   output store_value, output hi_value, output lo_value,
                   output unimplemented, input ready);
   modport sink   (input valid, input next_pc, input reg_write, input dest_reg,
                   input write_value, input mem_store, input mem_address,
                   input store_value, input hi_value, input lo_value,
                   input unimplemented, output ready);
endinterface

interface rscs_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] reset_pc;

   modport source (output valid, output reset_pc, input ready);
   modport sink   (input valid, input reset_pc, output ready);
endinterface

`default_nettype wire

// ----- hdl/rscs_regfile.sv -----
// 32 x 32 register file, two registered read ports, write bypass, reset by valid bits
// depends on rscs_pkg
`default_nettype none

module rscs_regfile (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        rd_en,
   input  wire logic [4:0]  rs_addr,
   input  wire logic [4:0]  rt_addr,
   input  wire logic        wr_en,
   input  wire logic [4:0]  wr_addr,
   input  wire logic [31:0] wr_data,
   output logic      [31:0] rs_data,
   output logic      [31:0] rt_data
);

   logic [31:0] mem [32];
   logic [31:0] valid_ff;
   logic [31:0] valid_in;

   logic [31:0] raw_a_ff, raw_b_ff;
   logic [31:0] byp_val_ff;
   logic        byp_a_ff, byp_b_ff;
   logic        vld_a_ff, vld_b_ff;
   logic [4:0]  addr_a_ff, addr_b_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read at issue; a write landing on the same edge is forwarded
   always_ff @(posedge clock) begin
      if (rd_en) begin
         raw_a_ff   <= mem[rs_addr];
         raw_b_ff   <= mem[rt_addr];
         vld_a_ff   <= valid_ff[rs_addr];
         vld_b_ff   <= valid_ff[rt_addr];
         addr_a_ff  <= rs_addr;
         addr_b_ff  <= rt_addr;
         byp_a_ff   <= wr_en && (wr_addr == rs_addr);
         byp_b_ff   <= wr_en && (wr_addr == rt_addr);
         byp_val_ff <= wr_data;
      end
   end

   always_comb begin
      if (byp_a_ff) begin
         rs_data = byp_val_ff;
      end else if (vld_a_ff) begin
         rs_data = raw_a_ff;
      end else begin
         rs_data = rscs_pkg::reg_reset_value(addr_a_ff);
      end
      if (byp_b_ff) begin
         rt_data = byp_val_ff;
      end else if (vld_b_ff) begin
         rt_data = raw_b_ff;
      end else begin
         rt_data = rscs_pkg::reg_reset_value(addr_b_ff);
      end
   end

endmodule

`default_nettype wire

// ----- hdl/rscs_dmem.sv -----
// data memory with registered read and a zero-fill sweep after reset
// depends on rscs_pkg
`default_nettype none

module rscs_dmem (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        wr_en,
   input  wire logic [rscs_pkg::DMEM_AW-1:0] wr_index,
   input  wire logic [31:0]                 wr_data,
   input  wire logic [rscs_pkg::DMEM_AW-1:0] rd_index,
   output logic      [31:0]                 rd_data,
   output logic                             busy
);

   logic [31:0] mem [rscs_pkg::DATA_WORDS];
   logic [31:0] rd_data_ff;

   logic                        clearing_ff, clearing_in;
   logic [rscs_pkg::DMEM_AW-1:0] clr_idx_ff, clr_idx_in;

   logic                        we;
   logic [rscs_pkg::DMEM_AW-1:0] widx;
   logic [31:0]                 wdata;

   always_comb begin
      clearing_in = clearing_ff;
      clr_idx_in  = clr_idx_ff;
      if (clearing_ff) begin
         clr_idx_in = clr_idx_ff + rscs_pkg::DMEM_AW'(1);
         if (clr_idx_ff == rscs_pkg::DMEM_AW'(rscs_pkg::DATA_WORDS - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   always_comb begin
      we    = clearing_ff || wr_en;
      widx  = clearing_ff ? clr_idx_ff : wr_index;
      wdata = clearing_ff ? 32'd0 : wr_data;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[widx] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_index];
   end

   assign rd_data = rd_data_ff;
   assign busy    = clearing_ff;

endmodule

`default_nettype wire

// ----- hdl/rscs_exec.sv -----
// decode and execute of one instruction word from registered operands
// depends on rscs_pkg
`default_nettype none

module rscs_exec (
   input  wire logic [31:0]          instruction,
   input  wire logic [31:0]          rs_data,
   input  wire logic [31:0]          rt_data,
   input  wire logic [31:0]          pc,
   input  wire logic [31:0]          hi,
   input  wire logic [31:0]          lo,
   input  wire logic [31:0]          load_data,
   output rscs_pkg::rsp_word_type    rsp,
   output rscs_pkg::exec_ctrl_type   ctrl
);

   logic [5:0]  op, fn;
   logic [4:0]  rt, rd, sh;
   logic [15:0] imm;
   logic [31:0] simm, pc4;
   logic signed [63:0] prod;

   assign op   = instruction[31:26];
   assign rt   = instruction[20:16];
   assign rd   = instruction[15:11];
   assign sh   = instruction[10:6];
   assign fn   = instruction[5:0];
   assign imm  = instruction[15:0];
   assign simm = {{16{imm[15]}}, imm};
   assign pc4  = pc + 32'd4;
   assign prod = $signed(rs_data) * $signed(rt_data);

   always_comb begin
      logic        wr, st, unimp, hilo_we, is_load;
      logic [4:0]  dst;
      logic [31:0] val, maddr, sval, npc;

      wr      = 1'b0;
      st      = 1'b0;
      unimp   = 1'b0;
      hilo_we = 1'b0;
      is_load = 1'b0;
      dst     = rscs_pkg::ZERO_REG;
      val     = 32'd0;
      maddr   = 32'd0;
      sval    = 32'd0;
      npc     = pc4;

      unique case (op)
         rscs_pkg::OP_SPECIAL: begin
            unique case (fn)
               rscs_pkg::FN_SLL: begin
                  wr = 1'b1; dst = rd; val = rt_data << sh;
               end
               rscs_pkg::FN_SRA: begin
                  wr = 1'b1; dst = rd; val = 32'($signed(rt_data) >>> sh);
               end
               rscs_pkg::FN_MULT: begin
                  hilo_we = 1'b1;
               end
               rscs_pkg::FN_ADDU: begin
                  wr = 1'b1; dst = rd; val = rs_data + rt_data;
               end
               rscs_pkg::FN_SUBU: begin
                  wr = 1'b1; dst = rd; val = rs_data - rt_data;
               end
               default: begin
                  unimp = 1'b1;
               end
            endcase
         end
         rscs_pkg::OP_J: begin
            npc = (pc4 & rscs_pkg::REGION_MASK) | {4'd0, instruction[25:0], 2'b00};
         end
         rscs_pkg::OP_BEQ: begin
            if (rs_data == rt_data) begin
               npc = pc4 + {simm[29:0], 2'b00};
            end
         end
         rscs_pkg::OP_ADDIU: begin
            wr = 1'b1; dst = rt; val = rs_data + simm;
         end
         rscs_pkg::OP_ANDI: begin
            wr = 1'b1; dst = rt; val = rs_data & {16'd0, imm};
         end
         rscs_pkg::OP_LW: begin
            maddr = rs_data + simm;
            is_load = 1'b1;
            wr = 1'b1; dst = rt; val = load_data;
         end
         rscs_pkg::OP_SW: begin
            maddr = rs_data + simm;
            st = 1'b1; sval = rt_data;
         end
         default: begin
            unimp = 1'b1;
         end
      endcase

      // writes to r0 are dropped and not reported
      if (!(wr && (dst != rscs_pkg::ZERO_REG))) begin
         wr  = 1'b0;
         dst = rscs_pkg::ZERO_REG;
         val = 32'd0;
      end

      ctrl.is_load   = is_load;
      ctrl.reg_we    = wr;
      ctrl.reg_addr  = dst;
      ctrl.reg_data  = val;
      ctrl.mem_we    = st;
      ctrl.mem_index = maddr[2 +: rscs_pkg::DMEM_AW];
      ctrl.mem_data  = sval;
      ctrl.hilo_we   = hilo_we;
      ctrl.hi        = prod[63:32];
      ctrl.lo        = prod[31:0];
      ctrl.npc       = npc;

      rsp.next_pc       = npc;
      rsp.reg_write     = wr;
      rsp.dest_reg      = dst;
      rsp.write_value   = val;
      rsp.mem_store     = st;
      rsp.mem_address   = maddr;
      rsp.store_value   = sval;
      rsp.hi_value      = hilo_we ? prod[63:32] : hi;
      rsp.lo_value      = hilo_we ? prod[31:0] : lo;
      rsp.unimplemented = unimp;
   end

endmodule

`default_nettype wire

// ----- hdl/risc_subset_core_step.sv -----
// risc subset core step: instruction and operands registered at accept, result registered at retire;
// throughput one word per cycle unless the result channel stalls, lw holds execute for its memory read
// synchronous reset; afterwards the data memory is zero-filled one word per cycle, with req ready low
// meanwhile; csr writes are taken at any time
// depends on rscs_pkg, rscs_if, rscs_regfile, rscs_dmem, rscs_exec and the defines header
`default_nettype none
`include "risc_subset_core_step_defines.svh"

module risc_subset_core_step (
   input  wire logic  clock,
   input  wire logic  reset,
   rscs_req_if.sink   req_chan,
   rscs_rsp_if.source rsp_chan,
   rscs_csr_if.sink   csr_chan
);

   // execute stage: instruction register, operands come from the register file read ports
   logic        e_valid_ff, e_valid_in;
   logic        e_phase_ff, e_phase_in;   // set once lw read data is available
   logic [31:0] ins_ff;

   // architectural state kept in flops
   logic [31:0] pc_ff, pc_in;
   logic [31:0] hi_ff, hi_in;
   logic [31:0] lo_ff, lo_in;

   // result register
   logic                   out_valid_ff, out_valid_in;
   rscs_pkg::rsp_word_type out_ff;

   logic [31:0] rs_data, rt_data;
   logic [31:0] load_data;
   logic        dmem_busy;

   rscs_pkg::rsp_word_type  e_rsp;
   rscs_pkg::exec_ctrl_type e_ctrl;

   logic out_free, e_wait, e_fire, req_ready, accept, csr_fire;

   // handshake
   // output register is free when empty or being drained this cycle
   assign out_free  = !out_valid_ff || rsp_chan.ready;
   // lw waits in execute until its registered memory read data is available
   assign e_wait    = e_ctrl.is_load && !e_phase_ff;
   // execute stage retires: state updates commit and the result moves out
   assign e_fire    = e_valid_ff && !e_wait && out_free;
   // new word enters when execute is empty or as the previous one retires, once the memory fill is done
   assign req_ready = !dmem_busy && (!e_valid_ff || e_fire);
   assign accept    = req_chan.valid && req_ready;
   assign csr_fire  = csr_chan.valid;

   assign req_chan.ready = req_ready;
   assign csr_chan.ready = 1'b1;

   // register file, read at accept with same-edge write forwarding
   rscs_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rs_addr (req_chan.instruction[25:21]),
      .rt_addr (req_chan.instruction[20:16]),
      .wr_en   (e_fire && e_ctrl.reg_we),
      .wr_addr (e_ctrl.reg_addr),
      .wr_data (e_ctrl.reg_data),
      .rs_data (rs_data),
      .rt_data (rt_data)
   );

   // data memory; read address follows the execute stage every cycle
   rscs_dmem u_dmem (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (e_fire && e_ctrl.mem_we),
      .wr_index (e_ctrl.mem_index),
      .wr_data  (e_ctrl.mem_data),
      .rd_index (e_ctrl.mem_index),
      .rd_data  (load_data),
      .busy     (dmem_busy)
   );

   rscs_exec u_exec (
      .instruction (ins_ff),
      .rs_data     (rs_data),
      .rt_data     (rt_data),
      .pc          (pc_ff),
      .hi          (hi_ff),
      .lo          (lo_ff),
      .load_data   (load_data),
      .rsp         (e_rsp),
      .ctrl        (e_ctrl)
   );

   // next-state logic
   always_comb begin
      e_valid_in = e_valid_ff;
      e_phase_in = e_phase_ff;
      if (accept) begin
         e_valid_in = 1'b1;
         e_phase_in = 1'b0;
      end else if (e_fire) begin
         e_valid_in = 1'b0;
         e_phase_in = 1'b0;
      end else if (e_valid_ff && e_ctrl.is_load) begin
         e_phase_in = 1'b1;
      end

      // csr write only while idle is the user's duty, not enforced; csr wins over a retiring word
      pc_in = pc_ff;
      if (csr_fire) begin
         pc_in = csr_chan.reset_pc;
      end else if (e_fire) begin
         pc_in = e_ctrl.npc;
      end

      hi_in = hi_ff;
      lo_in = lo_ff;
      if (e_fire && e_ctrl.hilo_we) begin
         hi_in = e_ctrl.hi;
         lo_in = e_ctrl.lo;
      end

      out_valid_in = out_valid_ff;
      if (e_fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff   <= 1'b0;
         e_phase_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         pc_ff        <= rscs_pkg::RESET_PC;
         hi_ff        <= 32'd0;
         lo_ff        <= 32'd0;
      end else begin
         e_valid_ff   <= e_valid_in;
         e_phase_ff   <= e_phase_in;
         out_valid_ff <= out_valid_in;
         pc_ff        <= pc_in;
         hi_ff        <= hi_in;
         lo_ff        <= lo_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         ins_ff <= req_chan.instruction;
      end
      if (e_fire) begin
         out_ff <= e_rsp;
      end
   end

   // result channel
   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.next_pc       = out_ff.next_pc;
   assign rsp_chan.reg_write     = out_ff.reg_write;
   assign rsp_chan.dest_reg      = out_ff.dest_reg;
   assign rsp_chan.write_value   = out_ff.write_value;
   assign rsp_chan.mem_store     = out_ff.mem_store;
   assign rsp_chan.mem_address   = out_ff.mem_address;
   assign rsp_chan.store_value   = out_ff.store_value;
   assign rsp_chan.hi_value      = out_ff.hi_value;
   assign rsp_chan.lo_value      = out_ff.lo_value;
   assign rsp_chan.unimplemented = out_ff.unimplemented;

   // checks
   `RSCS_ASSERT_IMP(a_no_r0_write, clock, reset, out_valid_ff && out_ff.reg_write, out_ff.dest_reg != rscs_pkg::ZERO_REG, "register write reported for r0")
   `RSCS_ASSERT_IMP(a_store_no_regwr, clock, reset, out_valid_ff, !(out_ff.mem_store && out_ff.reg_write), "store and register write in one word")
   `RSCS_ASSERT_NXT(a_fire_fills_out, clock, reset, e_fire, out_valid_ff, "retired word did not reach the result register")
   `RSCS_ASSERT_NXT(a_load_waits, clock, reset, e_valid_ff && e_ctrl.is_load && !e_phase_ff, e_valid_ff && e_phase_ff, "load left execute before its read data")

endmodule

`default_nettype wire
